// File: rtl/per_label_random_representative_unit_macros.svh
// Assertion macros for the per-label random representative unit.
// Used by the top level only; empty when SYNTHESIS is defined.
`ifndef PER_LABEL_RANDOM_REPRESENTATIVE_UNIT_MACROS_SVH
`define PER_LABEL_RANDOM_REPRESENTATIVE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PLRR_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);
`define PLRR_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);
`else
`define PLRR_ASSERT_IMP(name, pre, post, msg)
`define PLRR_ASSERT_NXT(name, pre, post, msg)
`endif
`endif

// File: rtl/plrr_pkg.sv
// Package for the per-label random representative unit: word types and constants.
// No dependencies.
`timescale 1ns / 1ps

package plrr_pkg;

  localparam int LABEL_W = 10;
  localparam int CFG_W   = 11;
  localparam int RAND_W  = 32;
  localparam int COUNT_W = 32;
  localparam int VIDX_W  = 32;

  localparam logic [CFG_W-1:0]   NUM_LABELS_RESET = 11'd1024;
  localparam logic [COUNT_W-1:0] COUNT_MAX        = 32'hFFFF_FFFF;
  localparam logic [RAND_W-1:0]  RAND_TOP         = 32'hFFFF_FFFF;

  localparam logic FUNC_COUNT  = 1'b0;
  localparam logic FUNC_SELECT = 1'b1;

  typedef struct packed {
    logic               func;
    logic [LABEL_W-1:0] label;
    logic [RAND_W-1:0]  random_value;
  } in_t;

  typedef struct packed {
    logic              selected;
    logic [VIDX_W-1:0] vertex_index;
    logic              label_error;
  } out_t;

  // one entry of the per-label store
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               found;
  } entry_t;

endpackage

// File: rtl/plrr_store.sv
// Per-label count/found store: one write and one registered read port,
// with a clearing sweep after reset. Depends on plrr_pkg.
`timescale 1ns / 1ps

module plrr_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output plrr_pkg::entry_t  rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  plrr_pkg::entry_t  wr_data,
  output logic              busy
);

  plrr_pkg::entry_t mem [DEPTH];
  logic [AW-1:0]    clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/per_label_random_representative_unit.sv
// Top level of the per-label random representative unit.
// Depends on plrr_pkg, plrr_store and the assertion macro header.
// Takes one word per cycle unless the output stalls or the store is clearing; each word is
// registered in stage 1 and its result then in the output register. The rate is set by the
// read-modify-write of the per-label store, whose read is issued as a word is accepted and
// whose update is bypassed to a following word of the same label. After reset the store
// clears all MAX_LABELS entries with in_ready low; num_labels can be written during that time.
`timescale 1ns / 1ps
`include "per_label_random_representative_unit_macros.svh"

module per_label_random_representative_unit #(
  parameter int MAX_LABELS  = 1024,
  parameter int INDEX_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [plrr_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  plrr_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output plrr_pkg::out_t               out_data
);

  localparam int AW = $clog2(MAX_LABELS);
  localparam int CW = $clog2(MAX_LABELS + 1);
  localparam int LW = plrr_pkg::LABEL_W;
  localparam logic [plrr_pkg::COUNT_W-1:0] COUNT_ONE = {{(plrr_pkg::COUNT_W-1){1'b0}}, 1'b1};

  logic [plrr_pkg::CFG_W-1:0] num_labels;
  logic [CW-1:0]              nonempty_labels;
  logic [CW-1:0]              found_labels;
  logic [INDEX_WIDTH-1:0]     select_position;

  logic              s1_valid;
  plrr_pkg::in_t     s1_data;
  logic              fwd_hit;
  plrr_pkg::entry_t  fwd_entry;
  plrr_pkg::entry_t  rd_entry;
  logic              clearing;

  logic              accept;
  logic              s1_adv;
  logic [LW+AW-1:0]  in_wide;
  logic [LW+AW-1:0]  s1_wide;
  logic [AW-1:0]     in_addr;
  logic [AW-1:0]     s1_addr;
  plrr_pkg::entry_t  cur;
  plrr_pkg::entry_t  entry_next;
  logic              in_range;
  logic              s1_we;
  logic              hit;
  logic [63:0]       prod;
  logic [INDEX_WIDTH+31:0] pos_wide;
  plrr_pkg::out_t    res;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !clearing && (!s1_valid || s1_adv);
  assign accept   = in_valid && in_ready;

  assign in_wide = {{AW{1'b0}}, in_data.label};
  assign s1_wide = {{AW{1'b0}}, s1_data.label};
  assign in_addr = in_wide[AW-1:0];
  assign s1_addr = s1_wide[AW-1:0];

  plrr_store #(
    .DEPTH (MAX_LABELS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .rd_data (rd_entry),
    .wr_en   (s1_adv && s1_we),
    .wr_addr (s1_addr),
    .wr_data (entry_next),
    .busy    (clearing)
  );

  assign cur      = fwd_hit ? fwd_entry : rd_entry;
  assign in_range = ({1'b0, s1_data.label} < num_labels) &&
                    (32'(s1_data.label) < 32'(MAX_LABELS));
  assign prod     = {32'b0, s1_data.random_value} * {32'b0, cur.count};
  assign pos_wide = {32'b0, select_position};

  always_comb begin
    entry_next = cur;
    s1_we      = 1'b0;
    hit        = 1'b0;
    res        = '0;
    if (s1_data.func == plrr_pkg::FUNC_COUNT) begin
      res.label_error = !in_range;
      s1_we           = in_range;
      if (cur.count != plrr_pkg::COUNT_MAX) begin
        entry_next.count = cur.count + COUNT_ONE;
      end
    end else begin
      res.vertex_index = pos_wide[31:0];
      if (!in_range || cur.count == '0) begin
        res.label_error = 1'b1;
      end else begin
        s1_we = 1'b1;
        hit   = (found_labels < nonempty_labels) && !cur.found &&
                (prod[63:32] == '0) && (prod[31:0] != plrr_pkg::RAND_TOP);
        entry_next.count = cur.count - COUNT_ONE;
        entry_next.found = cur.found | hit;
      end
      res.selected = hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_labels      <= plrr_pkg::NUM_LABELS_RESET;
      nonempty_labels <= '0;
      found_labels    <= '0;
      select_position <= '0;
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_labels <= cfg_data;
      end
      if (s1_adv) begin
        if (s1_data.func == plrr_pkg::FUNC_COUNT) begin
          if (in_range && cur.count == '0) begin
            nonempty_labels <= nonempty_labels + CW'(1);
          end
        end else begin
          select_position <= select_position + INDEX_WIDTH'(1);
          found_labels    <= found_labels + CW'(hit);
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data   <= in_data;
      fwd_hit   <= s1_adv && s1_we && (s1_addr == in_addr);
      fwd_entry <= entry_next;
    end
    if (s1_adv) begin
      out_data <= res;
    end
  end

  `PLRR_ASSERT_IMP(a_no_accept_clearing, clearing, !in_ready,
                   "word accepted during store clear")
  `PLRR_ASSERT_IMP(a_sel_no_err, out_valid && out_data.selected, !out_data.label_error,
                   "selected word flagged as error")
  `PLRR_ASSERT_IMP(a_found_bound, 1'b1, found_labels <= nonempty_labels,
                   "found labels exceed non-empty labels")
  `PLRR_ASSERT_NXT(a_found_inc, s1_adv && hit, found_labels == $past(found_labels) + CW'(1),
                   "found label count did not advance on selection")
  `PLRR_ASSERT_NXT(a_pos_inc, s1_adv && s1_data.func == plrr_pkg::FUNC_SELECT,
                   select_position == $past(select_position) + INDEX_WIDTH'(1),
                   "select position did not advance")

endmodule

// File: tb/plrr_checker.sv
// Checker for the per-label random representative unit: keeps its own per-label counts and
// found flags, predicts each result word and compares it with the unit's output in order.
// Depends on plrr_pkg.
`timescale 1ns / 1ps

module plrr_checker #(
  parameter int MAX_LABELS = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [plrr_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  plrr_pkg::in_t              in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  plrr_pkg::out_t             out_data,
  output int                         fails,
  output int                         pending
);

  logic [plrr_pkg::COUNT_W-1:0] member_cnt [MAX_LABELS];
  logic                         label_hit  [MAX_LABELS];
  int unsigned                  nonempty_cnt;
  int unsigned                  hit_cnt;
  logic [plrr_pkg::VIDX_W-1:0]  select_pos;
  logic [plrr_pkg::CFG_W-1:0]   num_labels_q;
  plrr_pkg::out_t               expected_words [$];
  plrr_pkg::out_t               want;
  int                           fail_cnt = 0;
  int                           results_seen = 0;

  function automatic plrr_pkg::out_t pick_representative(plrr_pkg::in_t w);
    plrr_pkg::out_t res;
    int unsigned    lim;
    logic           in_range;
    logic [63:0]    prod;
    res = '0;
    lim = (num_labels_q < MAX_LABELS) ? num_labels_q : MAX_LABELS;
    in_range = w.label < lim;
    if (w.func == plrr_pkg::FUNC_COUNT) begin
      if (!in_range) begin
        res.label_error = 1'b1;
      end else begin
        if (member_cnt[w.label] == '0) nonempty_cnt++;
        if (member_cnt[w.label] != plrr_pkg::COUNT_MAX) member_cnt[w.label]++;
      end
    end else begin
      res.vertex_index = select_pos;
      select_pos++;
      if (!in_range || member_cnt[w.label] == '0) begin
        res.label_error = 1'b1;
      end else begin
        // exact integer form of r / top < 1 / count
        prod = 64'(w.random_value) * 64'(member_cnt[w.label]);
        if (hit_cnt < nonempty_cnt && !label_hit[w.label] &&
            prod < 64'(plrr_pkg::RAND_TOP)) begin
          label_hit[w.label] = 1'b1;
          hit_cnt++;
          res.selected = 1'b1;
        end
        member_cnt[w.label]--;
      end
    end
    return res;
  endfunction

  // newest word at the front, oldest at the back
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_LABELS; i++) begin
        member_cnt[i] = '0;
        label_hit[i]  = 1'b0;
      end
      nonempty_cnt = 0;
      hit_cnt      = 0;
      select_pos   = '0;
      num_labels_q = plrr_pkg::NUM_LABELS_RESET;
      expected_words.delete();
    end else begin
      if (cfg_we) num_labels_q = cfg_data;
      if (in_valid && in_ready) expected_words.push_front(pick_representative(in_data));
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_words.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("result word %0d arrived with nothing expected: sel=%0b idx=%0d err=%0b",
                     results_seen, out_data.selected, out_data.vertex_index,
                     out_data.label_error);
        end else begin
          want = expected_words.pop_back();
          if (out_data.selected !== want.selected ||
              out_data.vertex_index !== want.vertex_index ||
              out_data.label_error !== want.label_error) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("word %0d: expected sel=%0b idx=%0d err=%0b, got sel=%0b idx=%0d err=%0b",
                       results_seen, want.selected, want.vertex_index, want.label_error,
                       out_data.selected, out_data.vertex_index, out_data.label_error);
          end
        end
      end
    end
    fails   <= fail_cnt;
    pending <= expected_words.size();
  end

endmodule

// File: tb/tb_top.sv
// Testbench top for the per-label random representative unit: drives count and select
// passes under random idling and stalls, writes num_labels between passes, gives the verdict.
// Depends on plrr_pkg, per_label_random_representative_unit and plrr_checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_LABELS   = 1024;
  localparam int IDLE_PCT     = 34;
  localparam int STALL_LIMIT  = 5000;
  localparam int RANDOM_WORDS = 1800;
  localparam int MAX_VERTICES = 120;

  typedef logic [plrr_pkg::LABEL_W-1:0] label_t;
  typedef logic [plrr_pkg::RAND_W-1:0]  word_t;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       cfg_we    = 1'b0;
  logic [plrr_pkg::CFG_W-1:0] cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  plrr_pkg::in_t              in_data   = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  plrr_pkg::out_t             out_data;

  int          fails;
  int          pending;
  bit          steady       = 1'b0;
  int          stall_cycles = 0;
  int          words_sent   = 0;
  int unsigned cur_limit    = MAX_LABELS;
  int unsigned next_fresh   = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  per_label_random_representative_unit #(
    .MAX_LABELS (MAX_LABELS),
    .INDEX_WIDTH(32)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  plrr_checker #(
    .MAX_LABELS(MAX_LABELS)
  ) u_checker (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .fails    (fails),
    .pending  (pending)
  );

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_word(logic func, label_t label, word_t rnd);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_data  <= {func, label, rnd};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // only once the unit has drained
  task automatic write_num_labels(logic [plrr_pkg::CFG_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_limit  = (value < MAX_LABELS) ? value : MAX_LABELS;
  endtask

  function automatic word_t pick_random_word();
    word_t div;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return plrr_pkg::RAND_TOP;
      2: begin
        div = plrr_pkg::RAND_TOP / word_t'($urandom_range(1, 8));
        return div - word_t'($urandom_range(0, 1));
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic label_t pick_label(bit fresh);
    if (cur_limit == 0) return label_t'($urandom_range(0, MAX_LABELS - 1));
    if (fresh) begin
      next_fresh++;
      return label_t'((next_fresh - 1) % cur_limit);
    end
    return label_t'($urandom_range(0, cur_limit - 1));
  endfunction

  // count pass then select pass over the same vertices; some passes are broken on purpose
  task automatic run_pass();
    label_t pool [8];
    label_t vertex_labels [MAX_VERTICES];
    label_t lab;
    int     k;
    int     n;
    int     n_sel;
    int     mode;
    int     a;
    int     b;
    k = $urandom_range(1, 8);
    for (int i = 0; i < k; i++) pool[i] = pick_label($urandom_range(0, 9) < 6);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, MAX_VERTICES) : $urandom_range(1, 24);
    for (int i = 0; i < n; i++) begin
      lab = pool[$urandom_range(0, k - 1)];
      if (cur_limit > 0 && cur_limit < MAX_LABELS && $urandom_range(0, 19) == 0)
        lab = label_t'($urandom_range(cur_limit, MAX_LABELS - 1));
      vertex_labels[i] = lab;
    end
    for (int i = 0; i < n; i++) send_word(plrr_pkg::FUNC_COUNT, vertex_labels[i], $urandom());
    mode  = $urandom_range(0, 9);
    n_sel = (mode == 0) ? $urandom_range(0, n - 1) : n;
    if (mode == 1) begin
      repeat (n) begin
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 1);
        lab = vertex_labels[a];
        vertex_labels[a] = vertex_labels[b];
        vertex_labels[b] = lab;
      end
    end
    for (int i = 0; i < n_sel; i++) begin
      if (mode == 2 && $urandom_range(0, 4) == 0)
        send_word(plrr_pkg::FUNC_COUNT, pool[$urandom_range(0, k - 1)], $urandom());
      send_word(plrr_pkg::FUNC_SELECT, vertex_labels[i], pick_random_word());
    end
    if (mode == 3) begin
      repeat ($urandom_range(1, 4))
        send_word(plrr_pkg::FUNC_SELECT, label_t'($urandom_range(0, MAX_LABELS - 1)),
                  pick_random_word());
    end
  endtask

  initial begin
    int base;
    int pick;
    logic [plrr_pkg::CFG_W-1:0] settings [10];
    settings = '{11'd1024, 11'd2047, 11'd1023, 11'd700, 11'd300,
                 11'd64, 11'd7, 11'd2, 11'd1, 11'd0};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // above MAX_LABELS acts as MAX_LABELS
    write_num_labels(11'd2047);
    send_word(plrr_pkg::FUNC_COUNT, 10'd1023, 32'hFFFF_FFFF);
    send_word(plrr_pkg::FUNC_COUNT, 10'd5, 32'h0);
    send_word(plrr_pkg::FUNC_COUNT, 10'd5, 32'h0);
    send_word(plrr_pkg::FUNC_COUNT, 10'd5, 32'h0);
    send_word(plrr_pkg::FUNC_COUNT, 10'd9, 32'hA5A5_5A5A);
    send_word(plrr_pkg::FUNC_SELECT, 10'd1023, 32'h0);
    send_word(plrr_pkg::FUNC_SELECT, 10'd5, 32'h5555_5555);  // product hits top exactly: no pick
    send_word(plrr_pkg::FUNC_SELECT, 10'd5, 32'h7FFF_FFFF);
    send_word(plrr_pkg::FUNC_SELECT, 10'd5, 32'h0);          // label already found
    send_word(plrr_pkg::FUNC_SELECT, 10'd9, 32'h1234_5678);  // every label now found
    send_word(plrr_pkg::FUNC_COUNT, 10'd0, 32'h0);
    send_word(plrr_pkg::FUNC_SELECT, 10'd0, 32'hFFFF_FFFF);
    send_word(plrr_pkg::FUNC_SELECT, 10'd5, 32'h0);          // zero count
    send_word(plrr_pkg::FUNC_SELECT, 10'd0, 32'h0);

    // every label out of range
    write_num_labels(11'd0);
    send_word(plrr_pkg::FUNC_COUNT, 10'd3, 32'h0);
    send_word(plrr_pkg::FUNC_SELECT, 10'd3, 32'h0);

    write_num_labels(11'd1);
    send_word(plrr_pkg::FUNC_COUNT, 10'd0, 32'h0);
    send_word(plrr_pkg::FUNC_COUNT, 10'd1, 32'h0);
    send_word(plrr_pkg::FUNC_SELECT, 10'd1, 32'h0);
    send_word(plrr_pkg::FUNC_SELECT, 10'd0, 32'h0);

    write_num_labels(11'd1024);

    base = words_sent;
    while (words_sent - base < RANDOM_WORDS) begin
      if ($urandom_range(0, 2) == 0) begin
        pick = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2) : $urandom_range(0, 9);
        write_num_labels(settings[pick]);
      end
      steady = (words_sent - base >= 700) && (words_sent - base < 1000);
      run_pass();
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
